[hdl/ptp_pkg.sv]
// Package for the point-to-polyline projection block: field widths, opcodes,
// the command record passed from the front end to the back end, and state codes.
// No dependencies.
package ptp_pkg;

	localparam int DEF_MAX_VERTICES = 32;
	localparam int DEF_MAX_DIMS     = 4;
	localparam int FRAC_BITS        = 16;

	localparam int OP_W       = 2;
	localparam int ROW_W      = 5;
	localparam int DIM_W      = 2;
	localparam int COORD_W    = 32;
	localparam int SEG_W      = 5;
	localparam int POS_W      = FRAC_BITS + 1;
	localparam int DIST_W     = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int SEGCFG_W   = 5;
	localparam int DIMCFG_W   = 3;

	// Command queue between front and back end.
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	// Error term width: (vertex - point) scaled by 2^F plus t * dir, with sign.
	localparam int E_W    = COORD_W + 2 + FRAC_BITS;
	localparam int MR_W   = E_W - FRAC_BITS;
	localparam int CUR_W  = SEG_W + FRAC_BITS;
	localparam int TCNT_W = $clog2(FRAC_BITS);
	localparam int CCNT_W = $clog2(CUR_W);

	typedef enum logic [OP_W-1:0] {
		OP_VERTEX = 2'd0,
		OP_DIR    = 2'd1,
		OP_POINT  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEGMENTS = 1'b0,
		CFG_DIMS     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t                       kind;
		logic                      wr_ok;
		logic                      project;
		logic [ROW_W-1:0]          row;
		logic [DIM_W-1:0]          dim;
		logic signed [COORD_W-1:0] value;
	} cmd_t;

	typedef enum logic [4:0] {
		BK_IDLE,
		BK_SEG,
		BK_DRD,
		BK_DLAT,
		BK_DMUL,
		BK_DACC,
		BK_TSET,
		BK_TDIV,
		BK_ERD,
		BK_ELAT,
		BK_EMUL,
		BK_ESUM,
		BK_ERND,
		BK_ESQ,
		BK_EACC,
		BK_CMP,
		BK_CSET,
		BK_CDIV,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic pop;
		logic mem_re;
		logic out_load;
	} bk_ctl_t;

endpackage

[hdl/ptp_front.sv]
// Front end: accepts input items and classifies them into commands for the queue.
// Depends on ptp_pkg.
module ptp_front #(
	parameter int MAX_VERTICES = ptp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DIMS     = ptp_pkg::DEF_MAX_DIMS
) (
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ptp_pkg::OP_W-1:0]           op,
	input  logic [ptp_pkg::ROW_W-1:0]          row,
	input  logic [ptp_pkg::DIM_W-1:0]          dim,
	input  logic signed [ptp_pkg::COORD_W-1:0] coord_value,
	input  logic                               last,
	input  logic                               q_full,
	output logic                               q_push,
	output ptp_pkg::cmd_t                      cmd
);
	import ptp_pkg::*;

	logic row_ok;
	logic dim_ok;

	assign row_ok = 32'(row) < 32'(MAX_VERTICES);
	assign dim_ok = 32'(dim) < 32'(MAX_DIMS);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		cmd.kind    = op_t'(op);
		cmd.row     = row;
		cmd.dim     = dim;
		cmd.value   = coord_value;
		cmd.project = 1'b0;
		cmd.wr_ok   = 1'b0;
		case (op_t'(op))
			OP_VERTEX, OP_DIR: begin
				cmd.wr_ok = row_ok && dim_ok;
			end
			OP_POINT: begin
				// A point write out of range is dropped but still projects on last.
				cmd.wr_ok   = dim_ok;
				cmd.project = last;
			end
			default: begin
				cmd.wr_ok = 1'b0;
			end
		endcase
	end

endmodule

[hdl/ptp_queue.sv]
// Short command queue between the front end and the back end.
// Depends on ptp_pkg.
module ptp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptp_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output ptp_pkg::cmd_t pop_data,
	output logic          not_empty
);
	import ptp_pkg::*;

	cmd_t             entry_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   count_q;

	assign full      = count_q == (CQ_AW+1)'(CQ_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/ptp_back.sv]
// Back end: executes table and point writes and clears, walks every segment with a
// shared multiply/accumulate sequencer, serial dividers for t and the curve index.
// Depends on ptp_pkg.
module ptp_back #(
	parameter int MAX_VERTICES = ptp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DIMS     = ptp_pkg::DEF_MAX_DIMS,
	localparam int DEPTH = MAX_VERTICES * MAX_DIMS,
	localparam int AW    = $clog2(DEPTH),
	localparam int JW    = $clog2(MAX_DIMS + 1),
	localparam int PIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptp_pkg::cmd_t                     cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_pop,
	input  logic [ptp_pkg::SEG_W-1:0]         nseg,
	input  logic [JW-1:0]                     ndim,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ptp_pkg::SEG_W-1:0]         best_segment,
	output logic [ptp_pkg::POS_W-1:0]         position,
	output logic [ptp_pkg::POS_W-1:0]         curve_index,
	output logic [ptp_pkg::DIST_W-1:0]        sq_distance,
	output logic [ptp_pkg::DIST_W-1:0]        total_distance
);
	import ptp_pkg::*;

	localparam logic [AW-1:0]          MD_STEP = AW'(MAX_DIMS);
	localparam logic [FRAC_BITS:0]     T_ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic [E_W-1:0]         HALF    = E_W'(1) << (FRAC_BITS - 1);
	localparam logic [DIST_W-1:0]      D_MAX   = '1;

	bk_state_t state_q, state_d;
	bk_ctl_t   ctl;

	logic signed [COORD_W-1:0] vmem [DEPTH];
	logic signed [COORD_W-1:0] dmem [DEPTH];
	logic signed [COORD_W-1:0] vrd_q, drd_q;
	logic signed [COORD_W-1:0] pbuf_q [MAX_DIMS];

	logic [AW-1:0]     waddr, raddr;
	logic [SEG_W-1:0]  k_q;
	logic [JW-1:0]     j_q;
	logic [AW-1:0]     base_q;
	logic              j_last;
	logic              k_last;

	logic signed [COORD_W:0]   diff_q;
	logic signed [COORD_W-1:0] dd_q;
	logic signed [DIST_W-1:0]  pa_q;
	logic [DIST_W-1:0]         pb_q;
	logic signed [DIST_W-1:0]  dot_q;
	logic [DIST_W-1:0]         nrm_q;
	logic [DIST_W-1:0]         nrm_eff;
	logic [FRAC_BITS:0]        t_q;
	logic [DIST_W-1:0]         tr_q;
	logic [DIST_W:0]           tr_sh;
	logic [TCNT_W-1:0]         tcnt_q;

	logic signed [E_W-1:0]     tp_q, vs_q, e_q;
	logic [E_W-1:0]            mag;
	logic [MR_W-1:0]           mr_q;
	logic [DIST_W-1:0]         sq_q;
	logic                      big_q;
	logic [DIST_W-1:0]         dist_q;

	logic [SEG_W-1:0]          best_k_q;
	logic [FRAC_BITS:0]        best_t_q;
	logic [DIST_W-1:0]         best_d_q;

	logic [CUR_W-1:0]          cn_q, cq_q;
	logic [SEG_W-1:0]          crem_q;
	logic [SEG_W:0]            crem_sh;
	logic [CCNT_W-1:0]         ccnt_q;

	logic [DIST_W-1:0]         sum_q;
	logic [DIST_W:0]           sum_add;
	logic [DIST_W:0]           dot_add;
	logic [DIST_W:0]           nrm_add;
	logic [DIST_W:0]           dist_add;

	logic                      out_valid_q;
	logic [SEG_W-1:0]          out_seg_q;
	logic [POS_W-1:0]          out_pos_q, out_cur_q;
	logic [DIST_W-1:0]         out_sq_q, out_tot_q;

	assign waddr  = AW'(int'(cmd.row) * MAX_DIMS + int'(cmd.dim));
	assign raddr  = base_q + AW'(j_q);
	assign j_last = JW'(j_q + 1'b1) == ndim;
	assign k_last = ({1'b0, k_q} + 1'b1) == {1'b0, nseg};

	assign nrm_eff  = (nrm_q == '0) ? DIST_W'(1) : nrm_q;
	assign tr_sh    = {tr_q, 1'b0};
	assign crem_sh  = {crem_q, cn_q[CUR_W-1]};
	assign mag      = e_q[E_W-1] ? (~e_q + HALF + 1'b1) : (e_q + HALF);
	assign dot_add  = {dot_q[DIST_W-1], dot_q} + {pa_q[DIST_W-1], pa_q};
	assign nrm_add  = {1'b0, nrm_q} + {1'b0, pb_q};
	assign dist_add = {1'b0, dist_q} + {1'b0, sq_q};
	assign sum_add  = {1'b0, sum_q} + {1'b0, best_d_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.kind == OP_POINT && cmd.project) begin
					state_d = BK_SEG;
				end
			end
			BK_SEG:  state_d = BK_DRD;
			BK_DRD:  state_d = BK_DLAT;
			BK_DLAT: state_d = BK_DMUL;
			BK_DMUL: state_d = BK_DACC;
			BK_DACC: state_d = j_last ? BK_TSET : BK_DRD;
			BK_TSET: begin
				if (dot_q[DIST_W-1] || dot_q == '0 || 64'(dot_q) >= nrm_eff) begin
					state_d = BK_ERD;
				end else begin
					state_d = BK_TDIV;
				end
			end
			BK_TDIV: state_d = (tcnt_q == TCNT_W'(FRAC_BITS - 1)) ? BK_ERD : BK_TDIV;
			BK_ERD:  state_d = BK_ELAT;
			BK_ELAT: state_d = BK_EMUL;
			BK_EMUL: state_d = BK_ESUM;
			BK_ESUM: state_d = BK_ERND;
			BK_ERND: state_d = BK_ESQ;
			BK_ESQ:  state_d = BK_EACC;
			BK_EACC: state_d = j_last ? BK_CMP : BK_ERD;
			BK_CMP:  state_d = k_last ? BK_CSET : BK_SEG;
			BK_CSET: state_d = BK_CDIV;
			BK_CDIV: state_d = (ccnt_q == CCNT_W'(CUR_W - 1)) ? BK_FIN : BK_CDIV;
			BK_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control strobes.
	always_comb begin
		ctl = '0;
		case (state_q)
			BK_IDLE: ctl.pop      = cmd_valid;
			BK_DRD:  ctl.mem_re   = 1'b1;
			BK_ERD:  ctl.mem_re   = 1'b1;
			BK_FIN:  ctl.out_load = !out_valid_q || out_ready;
			default: ctl = '0;
		endcase
	end

	assign cmd_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Vertex and direction tables, one access per cycle each.
	always_ff @(posedge clk) begin
		if (ctl.pop && cmd.kind == OP_VERTEX && cmd.wr_ok) begin
			vmem[waddr] <= cmd.value;
		end
		if (ctl.mem_re) begin
			vrd_q <= vmem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop && cmd.kind == OP_DIR && cmd.wr_ok) begin
			dmem[waddr] <= cmd.value;
		end
		if (ctl.mem_re) begin
			drd_q <= dmem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				pbuf_q[i] <= '0;
			end
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.pop && cmd.kind == OP_POINT && cmd.wr_ok) begin
				pbuf_q[PIW'(cmd.dim)] <= cmd.value;
			end
			if (ctl.pop && cmd.kind == OP_CLEAR) begin
				sum_q <= '0;
			end else if (ctl.out_load) begin
				sum_q <= sum_add[DIST_W] ? D_MAX : sum_add[DIST_W-1:0];
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Projection datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				k_q    <= '0;
				base_q <= '0;
			end
			BK_SEG: begin
				j_q    <= '0;
				dot_q  <= '0;
				nrm_q  <= '0;
				dist_q <= '0;
			end
			BK_DLAT: begin
				diff_q <= $signed({pbuf_q[j_q[PIW-1:0]][COORD_W-1], pbuf_q[j_q[PIW-1:0]]})
					- $signed({vrd_q[COORD_W-1], vrd_q});
				dd_q   <= drd_q;
			end
			BK_DMUL: begin
				pa_q <= DIST_W'(dd_q * diff_q);
				pb_q <= DIST_W'(dd_q * dd_q);
			end
			BK_DACC: begin
				// Signed saturation when the two top bits of the sum disagree.
				if (dot_add[DIST_W] != dot_add[DIST_W-1]) begin
					dot_q <= dot_add[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
						: {1'b0, {(DIST_W-1){1'b1}}};
				end else begin
					dot_q <= dot_add[DIST_W-1:0];
				end
				nrm_q <= nrm_add[DIST_W] ? D_MAX : nrm_add[DIST_W-1:0];
				j_q   <= j_last ? '0 : JW'(j_q + 1'b1);
			end
			BK_TSET: begin
				nrm_q  <= nrm_eff;
				tr_q   <= dot_q;
				tcnt_q <= '0;
				if (dot_q[DIST_W-1] || dot_q == '0) begin
					t_q <= '0;
				end else if (64'(dot_q) >= nrm_eff) begin
					t_q <= T_ONE;
				end else begin
					t_q <= '0;
				end
			end
			BK_TDIV: begin
				if (tr_sh >= {1'b0, nrm_q}) begin
					tr_q <= DIST_W'(tr_sh - {1'b0, nrm_q});
					t_q  <= {t_q[FRAC_BITS-1:0], 1'b1};
				end else begin
					tr_q <= tr_sh[DIST_W-1:0];
					t_q  <= {t_q[FRAC_BITS-1:0], 1'b0};
				end
				tcnt_q <= tcnt_q + 1'b1;
			end
			BK_ELAT: begin
				diff_q <= $signed({vrd_q[COORD_W-1], vrd_q})
					- $signed({pbuf_q[j_q[PIW-1:0]][COORD_W-1], pbuf_q[j_q[PIW-1:0]]});
				dd_q   <= drd_q;
			end
			BK_EMUL: begin
				tp_q <= E_W'($signed({1'b0, t_q}) * dd_q);
				vs_q <= $signed({diff_q[COORD_W], diff_q, {FRAC_BITS{1'b0}}});
			end
			BK_ESUM: e_q <= vs_q + tp_q;
			BK_ERND: mr_q <= mag[E_W-1:FRAC_BITS];
			BK_ESQ: begin
				sq_q  <= DIST_W'(mr_q[31:0]) * DIST_W'(mr_q[31:0]);
				big_q <= |mr_q[MR_W-1:32];
			end
			BK_EACC: begin
				if (big_q || dist_add[DIST_W]) begin
					dist_q <= D_MAX;
				end else begin
					dist_q <= dist_add[DIST_W-1:0];
				end
				j_q <= j_last ? '0 : JW'(j_q + 1'b1);
			end
			BK_CMP: begin
				if (k_q == '0 || dist_q < best_d_q) begin
					best_k_q <= k_q;
					best_t_q <= t_q;
					best_d_q <= dist_q;
				end
				k_q    <= k_q + 1'b1;
				base_q <= base_q + MD_STEP;
			end
			BK_CSET: begin
				cn_q   <= {best_k_q, {FRAC_BITS{1'b0}}} + CUR_W'(best_t_q);
				crem_q <= '0;
				cq_q   <= '0;
				ccnt_q <= '0;
			end
			BK_CDIV: begin
				if (crem_sh >= {1'b0, nseg}) begin
					crem_q <= SEG_W'(crem_sh - {1'b0, nseg});
					cq_q   <= {cq_q[CUR_W-2:0], 1'b1};
				end else begin
					crem_q <= crem_sh[SEG_W-1:0];
					cq_q   <= {cq_q[CUR_W-2:0], 1'b0};
				end
				cn_q   <= {cn_q[CUR_W-2:0], 1'b0};
				ccnt_q <= ccnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_seg_q <= best_k_q;
			out_pos_q <= best_t_q;
			out_cur_q <= cq_q[POS_W-1:0];
			out_sq_q  <= best_d_q;
			out_tot_q <= sum_add[DIST_W] ? D_MAX : sum_add[DIST_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign best_segment   = out_seg_q;
	assign position       = out_pos_q;
	assign curve_index    = out_cur_q;
	assign sq_distance    = out_sq_q;
	assign total_distance = out_tot_q;

`ifndef SYNTHESIS
	a_tdiv_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_TDIV) |-> (tr_q < nrm_q && nrm_q != '0))
		else $error("t divider remainder not below the norm");
	a_best_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FIN) |-> ({1'b0, best_k_q} < {1'b0, nseg}))
		else $error("best segment outside the segments in use");
	a_curve_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FIN) |-> (cq_q <= CUR_W'(T_ONE)))
		else $error("curve index above one");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pos_q <= T_ONE))
		else $error("position above one");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.pop && cmd.project && cmd.kind == OP_POINT) |=> (state_q == BK_SEG))
		else $error("projection command did not start a segment walk");
`endif

endmodule

[hdl/point_to_polyline_projection.sv]
// Top level of the point-to-polyline projection block: configuration registers,
// front end, command queue and back end. Depends on ptp_pkg, ptp_front,
// ptp_queue and ptp_back.
//
// Usage: load vertex (op 0) and direction (op 1) coordinates by row and dim,
// then send point coordinates (op 2); the point item with last set starts a
// projection onto every segment in use and yields one result item. Op 3 clears
// the running total. The configuration channel (cfg_index, cfg_data) sets the
// segment count (index 0) and the coordinate count (index 1); write it only
// while the block is idle. cfg_ready is always high.
// Load and clear items are executed by the back end while it is idle; the front end
// takes an item every cycle while the four-entry command queue has room.
// A projection runs on the shared multiply sequencer, which walks each segment one
// coordinate at a time, and on the bit-serial dividers for t and the curve index.
// Reset clears the point buffer, the running total, the queue and the output valid
// flag; table entries are undefined until written. When the receiver stalls, the
// result register holds its item and the back end keeps executing loads; a
// second result waits in the back end until the register is free.
module point_to_polyline_projection #(
	parameter int MAX_VERTICES = ptp_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DIMS     = ptp_pkg::DEF_MAX_DIMS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ptp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ptp_pkg::OP_W-1:0]            op,
	input  logic [ptp_pkg::ROW_W-1:0]           row,
	input  logic [ptp_pkg::DIM_W-1:0]           dim,
	input  logic signed [ptp_pkg::COORD_W-1:0]  coord_value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ptp_pkg::SEG_W-1:0]           best_segment,
	output logic [ptp_pkg::POS_W-1:0]           position,
	output logic [ptp_pkg::POS_W-1:0]           curve_index,
	output logic [ptp_pkg::DIST_W-1:0]          sq_distance,
	output logic [ptp_pkg::DIST_W-1:0]          total_distance
);
	import ptp_pkg::*;

	localparam int JW = $clog2(MAX_DIMS + 1);

	logic [SEGCFG_W-1:0] seg_cfg_q;
	logic [DIMCFG_W-1:0] dim_cfg_q;
	logic [SEG_W-1:0]    nseg;
	logic [JW-1:0]       ndim;

	cmd_t push_cmd, pop_cmd;
	logic q_full, q_push, q_pop, q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= SEGCFG_W'(1);
			dim_cfg_q <= DIMCFG_W'(2);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SEGMENTS: seg_cfg_q <= cfg_data[SEGCFG_W-1:0];
				CFG_DIMS:     dim_cfg_q <= cfg_data[DIMCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Zero counts act as one; counts above the storage act as its limit.
	always_comb begin
		if (seg_cfg_q == '0) begin
			nseg = SEG_W'(1);
		end else if (32'(seg_cfg_q) > 32'(MAX_VERTICES - 1)) begin
			nseg = SEG_W'(MAX_VERTICES - 1);
		end else begin
			nseg = SEG_W'(seg_cfg_q);
		end
		if (dim_cfg_q == '0) begin
			ndim = JW'(1);
		end else if (32'(dim_cfg_q) > 32'(MAX_DIMS)) begin
			ndim = JW'(MAX_DIMS);
		end else begin
			ndim = JW'(dim_cfg_q);
		end
	end

	ptp_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_DIMS(MAX_DIMS)
	) u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.row(row),
		.dim(dim),
		.coord_value(coord_value),
		.last(last),
		.q_full(q_full),
		.q_push(q_push),
		.cmd(push_cmd)
	);

	ptp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.pop_data(pop_cmd),
		.not_empty(q_not_empty)
	);

	ptp_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_DIMS(MAX_DIMS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pop_cmd),
		.cmd_valid(q_not_empty),
		.cmd_pop(q_pop),
		.nseg(nseg),
		.ndim(ndim),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.best_segment(best_segment),
		.position(position),
		.curve_index(curve_index),
		.sq_distance(sq_distance),
		.total_distance(total_distance)
	);

endmodule
